### sv/tmc_pkg.sv
// Shared types and constants of the tempo map time converter.
package tmc_pkg;

  localparam int SLOTS      = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int POS_W      = 47;
  localparam int TEMPO_W    = 26;
  localparam int QT_W       = 48;
  localparam int QS_W       = 44;
  localparam int SEC_W      = 43;
  localparam int DEN_W      = 38;
  localparam int ACC_W      = 64;
  localparam int PROD_W     = SEC_W + DEN_W;
  localparam int NUM_W      = POS_W + 31;
  localparam int STEP_W     = 7;
  localparam int DIV_STEPS  = NUM_W;
  localparam int MUL_STEPS  = SEC_W;
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 120;

  localparam logic [11:0]        TICK_FACTOR   = 12'd3003;
  localparam logic [TEMPO_W-1:0] MIN_TEMPO     = 26'd65536;
  localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 26'd7864320;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_T2S   = 2'd1,
    OP_S2T   = 2'd2,
    OP_TEMPO = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SEC   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_TEMPO = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD0,
    S_INIT,
    S_RD,
    S_EVAL,
    S_DPREP,
    S_DIV,
    S_DDONE,
    S_MPREP,
    S_MUL,
    S_RES
  } state_t;

  typedef struct packed {
    logic latch;
    logic wr;
    logic rd;
    logic init_t;
    logic step;
    logic set_at;
    logic div_load;
    logic div_fin;
    logic div_step;
    logic acc_add;
    logic mul_load;
    logic mul_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  in_op;
    op_t  op;
    logic trivial;
    logic qt_neg;
    logic i_eq_n;
    logic p_ge_ticks;
    logic p_gt_ticks;
    logic p_gt_at;
    logic reach;
    logic last_step;
    logic out_free;
  } status_t;

endpackage

### sv/tmc_ctrl.sv
// Sequencer of the tempo map time converter: walks the table and drives the datapath.
module tmc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  tmc_pkg::status_t st,
  output tmc_pkg::cmd_t    cmd,
  output logic             in_tready
);

  tmc_pkg::state_t state_r, state_nxt;
  logic            fin_r, fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmc_pkg::S_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      tmc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (st.in_valid) begin
          if (st.in_op == tmc_pkg::OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            state_nxt = tmc_pkg::S_CHECK;
          end
        end
      end
      tmc_pkg::S_CHECK: begin
        state_nxt = st.trivial ? tmc_pkg::S_RES : tmc_pkg::S_RD0;
      end
      tmc_pkg::S_RD0: begin
        cmd.rd    = 1'b1;
        state_nxt = tmc_pkg::S_INIT;
      end
      tmc_pkg::S_INIT: begin
        cmd.init_t = 1'b1;
        if (st.op == tmc_pkg::OP_TEMPO && st.qt_neg) state_nxt = tmc_pkg::S_RES;
        else state_nxt = tmc_pkg::S_RD;
      end
      tmc_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = tmc_pkg::S_EVAL;
      end
      tmc_pkg::S_EVAL: begin
        case (st.op)
          tmc_pkg::OP_T2S: begin
            if (st.i_eq_n || st.p_ge_ticks) begin
              fin_nxt   = 1'b1;
              state_nxt = tmc_pkg::S_DPREP;
            end else if (st.p_gt_at) begin
              fin_nxt   = 1'b0;
              state_nxt = tmc_pkg::S_DPREP;
            end else begin
              cmd.step  = 1'b1;
              state_nxt = tmc_pkg::S_RD;
            end
          end
          tmc_pkg::OP_S2T: begin
            if (st.i_eq_n) begin
              state_nxt = tmc_pkg::S_MPREP;
            end else if (!st.p_gt_at) begin
              cmd.step  = 1'b1;
              state_nxt = tmc_pkg::S_RD;
            end else begin
              fin_nxt   = 1'b0;
              state_nxt = tmc_pkg::S_DPREP;
            end
          end
          default: begin
            if (st.i_eq_n || st.p_gt_ticks) begin
              state_nxt = tmc_pkg::S_RES;
            end else begin
              cmd.step  = 1'b1;
              state_nxt = tmc_pkg::S_RD;
            end
          end
        endcase
      end
      tmc_pkg::S_DPREP: begin
        cmd.div_load = 1'b1;
        cmd.div_fin  = fin_r;
        state_nxt    = tmc_pkg::S_DIV;
      end
      tmc_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.last_step) state_nxt = tmc_pkg::S_DDONE;
      end
      tmc_pkg::S_DDONE: begin
        if (fin_r) begin
          cmd.acc_add = 1'b1;
          state_nxt   = tmc_pkg::S_RES;
        end else if (st.op == tmc_pkg::OP_S2T && st.reach) begin
          state_nxt = tmc_pkg::S_MPREP;
        end else begin
          cmd.acc_add = 1'b1;
          cmd.set_at  = 1'b1;
          cmd.step    = 1'b1;
          state_nxt   = tmc_pkg::S_RD;
        end
      end
      tmc_pkg::S_MPREP: begin
        cmd.mul_load = 1'b1;
        state_nxt    = tmc_pkg::S_MUL;
      end
      tmc_pkg::S_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.last_step) state_nxt = tmc_pkg::S_RES;
      end
      tmc_pkg::S_RES: begin
        if (st.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = tmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = tmc_pkg::S_IDLE;
    endcase
  end

endmodule

### sv/tmc_dp.sv
// Datapath: tempo table, serial divider and multiplier, accumulators, result register.
module tmc_dp #(
  parameter int MAX_EVENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tmc_pkg::cmd_t                   cmd,
  output tmc_pkg::status_t                st,
  input  logic                            in_tvalid,
  input  logic [1:0]                      in_tuser,
  input  logic [tmc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            cfg_wr_en,
  input  logic [tmc_pkg::CNT_W-1:0]       cfg_wr_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [1:0]                      out_tuser,
  output logic [tmc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam logic [tmc_pkg::SEC_W-1:0] MASK43 = '1;
  localparam logic [tmc_pkg::POS_W-1:0] MASK47 = '1;

  logic [tmc_pkg::POS_W-1:0]   pos_mem   [tmc_pkg::SLOTS];
  logic [tmc_pkg::TEMPO_W-1:0] tempo_mem [tmc_pkg::SLOTS];
  logic [tmc_pkg::POS_W-1:0]   p_q;
  logic [tmc_pkg::TEMPO_W-1:0] tq_q;

  logic [tmc_pkg::CNT_W-1:0]   count_r;
  tmc_pkg::op_t                op_r;
  logic [tmc_pkg::QT_W-1:0]    qt_r;
  logic [tmc_pkg::QS_W-1:0]    qs_r;
  logic [tmc_pkg::CNT_W-1:0]   i_r;
  logic [tmc_pkg::POS_W-1:0]   at_r;
  logic [tmc_pkg::TEMPO_W-1:0] t_r;
  logic [tmc_pkg::ACC_W-1:0]   acc_r;
  logic [tmc_pkg::DEN_W-1:0]   den_r;
  logic [tmc_pkg::DEN_W-1:0]   rem_r;
  logic [tmc_pkg::ACC_W-1:0]   q_r;
  logic [tmc_pkg::NUM_W-1:0]   num_r;
  logic [tmc_pkg::PROD_W-1:0]  prod_r;
  logic [tmc_pkg::STEP_W-1:0]  cnt_r;

  logic [tmc_pkg::IDX_W-1:0]   in_idx;
  logic [tmc_pkg::CNT_W-1:0]   n;
  logic [tmc_pkg::TEMPO_W-1:0] tp;
  logic [tmc_pkg::DEN_W-1:0]   den_new;
  logic [tmc_pkg::POS_W-1:0]   d;
  logic [tmc_pkg::DEN_W:0]     trial;
  logic [tmc_pkg::ACC_W:0]     acc_sum;
  logic [tmc_pkg::SEC_W-1:0]   mrem;
  logic [tmc_pkg::PROD_W-32:0] add_t;
  logic [tmc_pkg::PROD_W-31:0] tick_sum;
  logic [tmc_pkg::POS_W-1:0]   ticks;
  logic                        out_valid_r;
  logic [tmc_pkg::OUT_DATA_W-1:0] res_data;
  tmc_pkg::kind_t              res_kind;

  assign in_idx = in_tdata[5:0];
  assign ticks  = qt_r[tmc_pkg::POS_W-1:0];

  always_comb begin
    n = count_r;
    if (32'(n) > MAX_EVENTS) n = tmc_pkg::CNT_W'(MAX_EVENTS);
    if (32'(n) > tmc_pkg::SLOTS) n = tmc_pkg::CNT_W'(tmc_pkg::SLOTS);
  end

  assign tp       = (tq_q < tmc_pkg::MIN_TEMPO) ? tmc_pkg::MIN_TEMPO : tq_q;
  assign den_new  = tmc_pkg::DEN_W'(tmc_pkg::TICK_FACTOR * t_r);
  assign d        = cmd.div_fin ? (ticks - at_r) : (p_q - at_r);
  assign trial    = {rem_r, num_r[tmc_pkg::NUM_W-1]};
  assign acc_sum  = {1'b0, acc_r} + {1'b0, q_r};
  assign mrem     = tmc_pkg::SEC_W'(qs_r) - acc_r[tmc_pkg::SEC_W-1:0];
  assign add_t    = prod_r[tmc_pkg::PROD_W-1:31];
  assign tick_sum = {4'b0, at_r} + {1'b0, add_t};

  always_ff @(posedge clk) begin
    if (cmd.wr && 32'(in_idx) < MAX_EVENTS) begin
      pos_mem[in_idx]   <= in_tdata[52:6];
      tempo_mem[in_idx] <= in_tdata[78:53];
    end
    if (cmd.rd) begin
      p_q  <= pos_mem[i_r[tmc_pkg::IDX_W-1:0]];
      tq_q <= tempo_mem[i_r[tmc_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= tmc_pkg::op_t'(in_tuser);
      qt_r   <= in_tdata[126:79];
      qs_r   <= in_tdata[170:127];
      i_r    <= '0;
      at_r   <= '0;
      acc_r  <= '0;
      prod_r <= '0;
      t_r    <= tmc_pkg::DEFAULT_TEMPO;
    end
    if (cmd.init_t) t_r <= tp;
    if (cmd.step) begin
      t_r <= tp;
      i_r <= i_r + 1'b1;
    end
    if (cmd.set_at) at_r <= p_q;
    if (cmd.acc_add) acc_r <= acc_sum[tmc_pkg::ACC_W-1:0];
    if (cmd.div_load) begin
      den_r <= den_new;
      rem_r <= '0;
      q_r   <= '0;
      num_r <= {d, 31'b0};
      cnt_r <= tmc_pkg::STEP_W'(tmc_pkg::DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= tmc_pkg::DEN_W'(trial - {1'b0, den_r});
        q_r   <= {q_r[tmc_pkg::ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[tmc_pkg::DEN_W-1:0];
        q_r   <= {q_r[tmc_pkg::ACC_W-2:0], 1'b0};
      end
      num_r <= {num_r[tmc_pkg::NUM_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.mul_load) begin
      den_r  <= den_new;
      prod_r <= '0;
      num_r  <= {mrem, 35'b0};
      cnt_r  <= tmc_pkg::STEP_W'(tmc_pkg::MUL_STEPS - 1);
    end
    if (cmd.mul_step) begin
      prod_r <= {prod_r[tmc_pkg::PROD_W-2:0], 1'b0}
              + (num_r[tmc_pkg::NUM_W-1] ? tmc_pkg::PROD_W'(den_r) : '0);
      num_r  <= {num_r[tmc_pkg::NUM_W-2:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    res_data = '0;
    case (op_r)
      tmc_pkg::OP_T2S: begin
        res_kind       = tmc_pkg::KIND_SEC;
        res_data[42:0] = (acc_r[tmc_pkg::ACC_W-1:tmc_pkg::SEC_W] != '0) ? MASK43
                       : acc_r[tmc_pkg::SEC_W-1:0];
      end
      tmc_pkg::OP_S2T: begin
        res_kind        = tmc_pkg::KIND_TICK;
        res_data[89:43] = (tick_sum[tmc_pkg::PROD_W-31:tmc_pkg::POS_W] != '0) ? MASK47
                        : tick_sum[tmc_pkg::POS_W-1:0];
      end
      default: begin
        res_kind         = tmc_pkg::KIND_TEMPO;
        res_data[115:90] = t_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_tdata <= res_data;
      out_tuser <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    st            = '0;
    st.in_valid   = in_tvalid;
    st.in_op      = tmc_pkg::op_t'(in_tuser);
    st.op         = op_r;
    case (op_r)
      tmc_pkg::OP_T2S: st.trivial = qt_r[tmc_pkg::QT_W-1] || qt_r == '0 || n == '0;
      tmc_pkg::OP_S2T: st.trivial = qs_r[tmc_pkg::QS_W-1] || qs_r == '0 || n == '0;
      default:         st.trivial = (n == '0);
    endcase
    st.qt_neg     = qt_r[tmc_pkg::QT_W-1];
    st.i_eq_n     = (i_r == n);
    st.p_ge_ticks = (p_q >= ticks);
    st.p_gt_ticks = (p_q > ticks);
    st.p_gt_at    = (p_q > at_r);
    st.reach      = (acc_sum >= (tmc_pkg::ACC_W + 1)'(qs_r[tmc_pkg::SEC_W-1:0]));
    st.last_step  = (cnt_r == '0);
    st.out_free   = !out_valid_r || out_tready;
  end

endmodule

### sv/tempo_map_time_converter.sv
// Top level of the tempo map time converter.
// Converts between tick positions and time (2^-20 s units) over a tempo table
// of up to 64 entries, and looks up the tempo at a tick. A query is handled
// one at a time: the sequencer reads table entries one after another (read,
// then evaluate), each segment that needs its duration goes through the
// one-bit-per-cycle divider, and seconds to ticks ends with a serial multiply.
module tempo_map_time_converter #(
  parameter int MAX_EVENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [1:0]                      in_tuser,   // operation
  // entry_index, entry_position, entry_tempo, query_ticks, query_seconds
  input  logic [tmc_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [1:0]                      out_tuser,  // result_kind
  // seconds_result, ticks_result, tempo_result
  output logic [tmc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [tmc_pkg::CNT_W-1:0]       cfg_wr_data  // event_count
);

  tmc_pkg::cmd_t    cmd;
  tmc_pkg::status_t st;

  tmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .st        (st),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  tmc_dp #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_tvalid   (in_tvalid),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata)
  );

endmodule
